[rtl/stack_permutation_checker_core_defines.svh]
// Assertion macros shared by the stack permutation checker's checker module
`ifndef STACK_PERMUTATION_CHECKER_CORE_DEFINES_SVH
`define STACK_PERMUTATION_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define SPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset cycle itself
`define SPC_ASSERT_RST(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

[rtl/spc_pkg.sv]
// Package: types and constants of the stack permutation checker
`default_nettype none
package spc_pkg;

  localparam int MAX_LEN_DEFAULT = 256;
  localparam int SYM_W = 8;

  // input queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic [SYM_W-1:0] orig_symbol;
    logic [SYM_W-1:0] perm_symbol;
    logic             is_last;
  } in_item_t;

  typedef struct packed {
    logic is_valid;
    logic overflowed;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_COMPARE,
    S_DONE
  } back_state_t;

endpackage
`default_nettype wire

[rtl/stack_permutation_checker_core.sv]
// Flow: an item waits at the input queue head until the stack engine takes it in S_IDLE, then
//   passes S_READ (memory read) and S_COMPARE, with one more S_READ/S_COMPARE pair per stack pop.
// The stack engine takes no new item until it is back in S_IDLE; its registered memory read in
//   the pop loop sets the pace. A last item also passes S_DONE, which waits while the result is unread.
// Reset (rst, synchronous): queue, stack pointer, indices, overflow flag and result flag cleared.
// Top level: stack permutation checker
`default_nettype none
module stack_permutation_checker_core #(
  parameter int MAX_LEN = spc_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire spc_pkg::in_item_t item,
  output logic                   empty,
  input  wire logic              pop,
  output spc_pkg::result_t       result
);
  import spc_pkg::*;

  logic     head_valid;
  in_item_t head;
  logic     take;

  spc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  spc_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
`default_nettype wire

[rtl/spc_front.sv]
// Front end: accepts items into a short queue ahead of the stack engine
`default_nettype none
module spc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire spc_pkg::in_item_t item,
  output logic                  head_valid,
  output spc_pkg::in_item_t     head,
  input  wire logic             take
);
  import spc_pkg::*;

  in_item_t            entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                wr_en;
  logic                rd_en;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign wr_en      = push && !full;
  assign rd_en      = take && head_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/spc_back.sv]
// Back end: stack and candidate queue memories, pop-match sequencer, result register
`default_nettype none
module spc_back #(
  parameter int MAX_LEN = spc_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire spc_pkg::in_item_t head,
  output logic                   take,
  output logic                   empty,
  input  wire logic              pop,
  output spc_pkg::result_t       result
);
  import spc_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [SYM_W-1:0] stack_mem [MAX_LEN];
  logic [SYM_W-1:0] queue_mem [MAX_LEN];

  back_state_t      state, state_next;
  logic [CW-1:0]    sp, sp_next;
  logic [CW-1:0]    qwi, qwi_next;
  logic [CW-1:0]    qri, qri_next;
  logic             ovf, ovf_next;
  logic             last_pend, last_pend_next;
  logic             res_full, res_full_next;
  result_t          res, res_next;
  logic [SYM_W-1:0] stack_rd;
  logic [SYM_W-1:0] queue_rd;
  logic [CW-1:0]    sp_dec;
  logic             mem_we;
  logic             load;

  assign sp_dec = sp - CW'(1);
  assign empty  = !res_full;
  assign result = res;

  // item write and registered top/head reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[sp[AW-1:0]]  <= head.orig_symbol;
      queue_mem[qwi[AW-1:0]] <= head.perm_symbol;
    end
    stack_rd <= stack_mem[sp_dec[AW-1:0]];
    queue_rd <= queue_mem[qri[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      qwi       <= '0;
      qri       <= '0;
      ovf       <= 1'b0;
      last_pend <= 1'b0;
      res_full  <= 1'b0;
    end else begin
      state     <= state_next;
      sp        <= sp_next;
      qwi       <= qwi_next;
      qri       <= qri_next;
      ovf       <= ovf_next;
      last_pend <= last_pend_next;
      res_full  <= res_full_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_comb begin
    state_next     = state;
    sp_next        = sp;
    qwi_next       = qwi;
    qri_next       = qri;
    ovf_next       = ovf;
    last_pend_next = last_pend;
    take           = 1'b0;
    mem_we         = 1'b0;
    load           = 1'b0;
    res_next       = res;

    case (state)
      S_IDLE: begin
        if (head_valid) begin
          take           = 1'b1;
          last_pend_next = head.is_last;
          if (ovf || qwi == CW'(MAX_LEN)) begin
            // sequence too long: drop the item
            ovf_next   = 1'b1;
            state_next = head.is_last ? S_DONE : S_IDLE;
          end else begin
            mem_we     = 1'b1;
            sp_next    = sp + CW'(1);
            qwi_next   = qwi + CW'(1);
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_COMPARE;
      end
      S_COMPARE: begin
        // stack depth equals queued-but-unmatched count, so sp != 0 covers both bounds
        if (sp != '0 && stack_rd == queue_rd) begin
          sp_next    = sp_dec;
          qri_next   = qri + CW'(1);
          state_next = S_READ;
        end else begin
          state_next = last_pend ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (!res_full || pop) begin
          load                = 1'b1;
          res_next.is_valid   = !ovf && (sp == '0);
          res_next.overflowed = ovf;
          sp_next             = '0;
          qwi_next            = '0;
          qri_next            = '0;
          ovf_next            = 1'b0;
          last_pend_next      = 1'b0;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (load) begin
      res_full_next = 1'b1;
    end else if (pop && res_full) begin
      res_full_next = 1'b0;
    end else begin
      res_full_next = res_full;
    end
  end

endmodule
`default_nettype wire

[rtl/spc_checker.sv]
// Port-level checks for the stack permutation checker, bound to the top level
`default_nettype none
`include "stack_permutation_checker_core_defines.svh"
module spc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              push,
  input wire logic              full,
  input wire spc_pkg::in_item_t item,
  input wire logic              empty,
  input wire logic              pop,
  input wire spc_pkg::result_t  result
);
  import spc_pkg::*;

  logic push_seen;
  assign push_seen = push && (item.is_last || !item.is_last);

  `SPC_ASSERT_RST(a_reset_clears, clk, rst, empty && !full, "ports not idle after reset")
  `SPC_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(result), "waiting result changed")
  `SPC_ASSERT_NOW(a_ovf_not_valid, clk, rst, !empty, !(result.is_valid && result.overflowed), "overflow reported as valid")
  `SPC_ASSERT_NEXT(a_full_needs_push, clk, rst, !full && !push_seen, !full, "queue filled without a push")

endmodule

bind stack_permutation_checker_core spc_checker u_spc_checker (.*);
`default_nettype wire

[dv/testbench.sv]
// Testbench for the stack permutation checker: directed table, random sequences, scoreboard
`timescale 1ns / 100ps

module testbench;
  import spc_pkg::*;

  localparam int SEQ_DEPTH   = MAX_LEN_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PARK_CYCLES = 300;
  localparam int SETTLE      = 600;
  localparam int DIR_ROWS    = 22;

  typedef enum int {SHAPE_STACK, SHAPE_REVERSE, SHAPE_SHUFFLE, SHAPE_NOISE} shape_t;

  typedef struct packed {
    in_item_t it;
    logic     typed;
    result_t  want;
  } dir_row_t;

  localparam result_t NO_CALL = '{1'b0, 1'b0};

  // typed verdicts only where they are obvious; other rows go through the predictor
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{8'h00, 8'h00, 1'b1}, 1'b1, '{1'b1, 1'b0}},
    '{'{8'hFF, 8'hFF, 1'b1}, 1'b1, '{1'b1, 1'b0}},
    '{'{8'hAA, 8'h55, 1'b1}, 1'b1, '{1'b0, 1'b0}},
    '{'{8'hFF, 8'h00, 1'b1}, 1'b1, '{1'b0, 1'b0}},
    '{'{8'h01, 8'h03, 1'b0}, 1'b0, NO_CALL},
    '{'{8'h02, 8'h02, 1'b0}, 1'b0, NO_CALL},
    '{'{8'h03, 8'h01, 1'b1}, 1'b0, NO_CALL},
    '{'{8'h01, 8'h03, 1'b0}, 1'b0, NO_CALL},
    '{'{8'h02, 8'h01, 1'b0}, 1'b0, NO_CALL},
    '{'{8'h03, 8'h02, 1'b1}, 1'b0, NO_CALL},
    '{'{8'h10, 8'h10, 1'b0}, 1'b0, NO_CALL},
    '{'{8'h20, 8'h20, 1'b0}, 1'b0, NO_CALL},
    '{'{8'h30, 8'h30, 1'b1}, 1'b0, NO_CALL},
    '{'{8'h07, 8'h07, 1'b0}, 1'b0, NO_CALL},
    '{'{8'h07, 8'h07, 1'b1}, 1'b0, NO_CALL},
    '{'{8'h05, 8'h05, 1'b0}, 1'b0, NO_CALL},
    '{'{8'h05, 8'h09, 1'b0}, 1'b0, NO_CALL},
    '{'{8'h09, 8'h05, 1'b1}, 1'b0, NO_CALL},
    '{'{8'h80, 8'h01, 1'b0}, 1'b0, NO_CALL},
    '{'{8'h01, 8'h80, 1'b1}, 1'b0, NO_CALL},
    '{'{8'h00, 8'hFF, 1'b0}, 1'b0, NO_CALL},
    '{'{8'hFF, 8'h00, 1'b1}, 1'b0, NO_CALL}
  };

  logic     clk;
  logic     rst;
  logic     push;
  logic     full;
  in_item_t in_word;
  logic     empty;
  logic     pop;
  result_t  result;

  stack_permutation_checker_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (in_word),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // predictor state
  logic [7:0]  pile [SEQ_DEPTH];
  int unsigned pile_top;
  logic [7:0]  cand_buf [SEQ_DEPTH];
  int unsigned cand_wr;
  int unsigned cand_rd;
  bit          depth_blown;

  result_t verdicts_due [$];
  int      mismatches;
  int      cycle_count;
  int      tx_gap_pct;
  int      rx_stall_pct;
  int      park_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // folds one symbol pair into the predicted stack; returns 1 when a verdict is due
  function automatic bit fold_pair(input in_item_t it, output result_t verdict);
    verdict = '0;
    if (!depth_blown) begin
      if (cand_wr >= SEQ_DEPTH || pile_top >= SEQ_DEPTH) begin
        depth_blown = 1'b1;
      end else begin
        cand_buf[cand_wr] = it.perm_symbol;
        cand_wr++;
        pile[pile_top] = it.orig_symbol;
        pile_top++;
        while (pile_top > 0 && cand_rd < cand_wr && pile[pile_top-1] == cand_buf[cand_rd]) begin
          pile_top--;
          cand_rd++;
        end
      end
    end
    if (!it.is_last) return 1'b0;
    verdict.is_valid   = !depth_blown && pile_top == 0;
    verdict.overflowed = depth_blown;
    pile_top    = 0;
    cand_wr     = 0;
    cand_rd     = 0;
    depth_blown = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_pair(input in_item_t it, input bit typed, input result_t want);
    result_t calc;
    bit      yields;
    yields = fold_pair(it, calc);
    if (yields) verdicts_due.push_back(typed ? want : calc);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_word <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_sequence(input int len, input shape_t shape);
    logic [7:0] src [$];
    logic [7:0] dst [$];
    logic [7:0] held [$];
    logic [7:0] sym;
    in_item_t   it;
    bit         narrow;
    int         k;
    int         j;
    narrow = ($urandom_range(0, 2) == 0);
    for (k = 0; k < len; k++) begin
      sym = 8'($urandom_range(0, 255));
      // a tiny alphabet forces repeated symbols
      if (narrow) sym = sym & 8'h03;
      src.push_back(sym);
    end
    case (shape)
      SHAPE_STACK: begin
        for (k = 0; k < len; k++) begin
          held.push_back(src[k]);
          while (held.size() > 0 && $urandom_range(0, 1) == 1) dst.push_back(held.pop_back());
        end
        while (held.size() > 0) dst.push_back(held.pop_back());
      end
      SHAPE_REVERSE: begin
        for (k = len - 1; k >= 0; k--) dst.push_back(src[k]);
      end
      SHAPE_SHUFFLE: begin
        dst = src;
        for (k = 0; k < len; k++) begin
          j      = $urandom_range(0, len - 1);
          sym    = dst[k];
          dst[k] = dst[j];
          dst[j] = sym;
        end
      end
      default: begin
        for (k = 0; k < len; k++) dst.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    for (k = 0; k < len; k++) begin
      it.orig_symbol = src[k];
      it.perm_symbol = dst[k];
      it.is_last     = (k == len - 1);
      send_pair(it, 1'b0, NO_CALL);
    end
  endtask

  task automatic drain_verdicts();
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls plus one long park on request
  initial begin
    int park_done;
    park_done = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (park_done < park_req) begin
        pop <= 1'b0;
        repeat (PARK_CYCLES) @(negedge clk);
        park_done++;
      end
      pop <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result: is_valid=%0b overflowed=%0b",
               result.is_valid, result.overflowed);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (result.is_valid !== want.is_valid) begin
          $error("is_valid: expected %0b, got %0b", want.is_valid, result.is_valid);
          mismatches++;
        end
        if (result.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, result.overflowed);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int     r;
    int     seq_no;
    int     small_items;
    int     len;
    shape_t shape;
    rst          = 1'b1;
    push         = 1'b0;
    in_word      = '0;
    mismatches   = 0;
    cycle_count  = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    park_req     = 0;
    pile_top     = 0;
    cand_wr      = 0;
    cand_rd      = 0;
    depth_blown  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      send_pair(DIRECTED[r].it, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // park the result side while one-item sequences keep arriving, so the block backs up
    park_req = 1;
    for (r = 0; r < 60; r++) send_sequence(1, ($urandom_range(0, 1) == 1) ? SHAPE_STACK : SHAPE_NOISE);
    push <= 1'b0;
    drain_verdicts();
    @(negedge clk);

    // a sequence exactly as long as the depth, then one past the depth
    send_sequence(SEQ_DEPTH, SHAPE_REVERSE);
    send_sequence(SEQ_DEPTH + 1, SHAPE_STACK);

    seq_no      = 0;
    small_items = 0;
    while (small_items < 310) begin
      case ((seq_no / 5) % 4)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 78; rx_stall_pct = 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 78; end
        default: begin tx_gap_pct = 26; rx_stall_pct = 26; end
      endcase
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      r   = $urandom_range(0, 9);
      if (r < 6)      shape = SHAPE_STACK;
      else if (r < 7) shape = SHAPE_REVERSE;
      else if (r < 9) shape = SHAPE_SHUFFLE;
      else            shape = SHAPE_NOISE;
      send_sequence(len, shape);
      small_items += len;
      seq_no++;
    end
    push <= 1'b0;

    drain_verdicts();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_front.sv
rtl/spc_back.sv
rtl/stack_permutation_checker_core.sv
rtl/spc_checker.sv
dv/testbench.sv
